>>> sv/csrp_pkg.sv
// Package for the status report parser: parse phases, key and record codes,
// name tables and the record struct. No dependencies.
`timescale 1ns / 1ps
package csrp_pkg;

    localparam int FRAC_DIGITS_DEF = 3;
    localparam int VALUE_WIDTH_DEF = 32;

    // Parse phases.
    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_NAME    = 4'd1;
    localparam logic [3:0] PH_KEY     = 4'd2;
    localparam logic [3:0] PH_LEAD    = 4'd3;
    localparam logic [3:0] PH_SIGN    = 4'd4;
    localparam logic [3:0] PH_INT     = 4'd5;
    localparam logic [3:0] PH_FRAC    = 4'd6;
    localparam logic [3:0] PH_REST    = 4'd7;
    localparam logic [3:0] PH_FLAGS   = 4'd8;
    localparam logic [3:0] PH_SKIP    = 4'd9;
    localparam logic [3:0] PH_DISCARD = 4'd10;

    // Field keys.
    localparam logic [3:0] K_NONE = 4'd0;
    localparam logic [3:0] K_MPOS = 4'd1;
    localparam logic [3:0] K_WPOS = 4'd2;
    localparam logic [3:0] K_WCO  = 4'd3;
    localparam logic [3:0] K_FS   = 4'd4;
    localparam logic [3:0] K_F    = 4'd5;
    localparam logic [3:0] K_OV   = 4'd6;
    localparam logic [3:0] K_A    = 4'd7;
    localparam logic [3:0] K_PN   = 4'd8;
    localparam logic [3:0] K_SUB  = 4'd9;

    // Record kinds.
    localparam logic [3:0] RK_STATE = 4'd0;
    localparam logic [3:0] RK_FS    = 4'd4;
    localparam logic [3:0] RK_F     = 4'd5;
    localparam logic [3:0] RK_OV    = 4'd6;
    localparam logic [3:0] RK_ACC   = 4'd7;
    localparam logic [3:0] RK_PINS  = 4'd8;
    localparam logic [3:0] RK_DONE  = 4'd9;

    localparam int N_STATES = 9;
    localparam int N_KEYS   = 8;
    localparam int N_CAND   = 12;

    localparam logic [7:0] ST_TXT [0:8][0:4] = '{
        '{"I", "d", "l", "e", 8'h00},
        '{"R", "u", "n", 8'h00, 8'h00},
        '{"H", "o", "l", "d", 8'h00},
        '{"J", "o", "g", 8'h00, 8'h00},
        '{"H", "o", "m", "e", 8'h00},
        '{"A", "l", "a", "r", "m"},
        '{"D", "o", "o", "r", 8'h00},
        '{"C", "h", "e", "c", "k"},
        '{"S", "l", "e", "e", "p"}
    };
    localparam logic [3:0] ST_LEN [0:8] = '{4'd4, 4'd3, 4'd4, 4'd3, 4'd4, 4'd5, 4'd4,
                                           4'd5, 4'd5};
    localparam logic [2:0] ST_CODE [0:8] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd2,
                                            3'd0, 3'd0};

    localparam logic [7:0] KEY_TXT [0:7][0:3] = '{
        '{"M", "P", "o", "s"},
        '{"W", "P", "o", "s"},
        '{"W", "C", "O", 8'h00},
        '{"F", "S", 8'h00, 8'h00},
        '{"F", 8'h00, 8'h00, 8'h00},
        '{"O", "v", 8'h00, 8'h00},
        '{"A", 8'h00, 8'h00, 8'h00},
        '{"P", "n", 8'h00, 8'h00}
    };
    localparam logic [3:0] KEY_LEN [0:7] = '{4'd4, 4'd4, 4'd3, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2};

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] val_a;
        logic [31:0] val_b;
        logic [31:0] val_c;
        logic [3:0]  flags;
        logic        ok;
    } t_record;

    // Powers of ten for padding missing fraction digits.
    function automatic logic [19:0] pow10(input logic [2:0] p);
        logic [19:0] r;
        case (p)
            3'd0:    r = 20'd1;
            3'd1:    r = 20'd10;
            3'd2:    r = 20'd100;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd10000;
            3'd5:    r = 20'd100000;
            3'd6:    r = 20'd1000000;
            default: r = 20'd1;
        endcase
        return r;
    endfunction

endpackage

>>> sv/csrp_parser.sv
// Parser state and the per-byte transition logic of the status report parser.
// Depends on csrp_pkg.
`timescale 1ns / 1ps
module csrp_parser #(
    parameter int FRAC_DIGITS = 3,
    parameter int VALUE_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [7:0]       i_char,
    input  logic             i_done,
    output logic             o_rec_valid,
    output csrp_pkg::t_record o_rec
);
    import csrp_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam logic [W-1:0] CAP_W = {1'b1, {(W-1){1'b0}}};

    logic [3:0]    r_phase, n_phase;
    logic [11:0]   r_match, n_match;
    logic [3:0]    r_nlen, n_nlen;
    logic [3:0]    r_key, n_key;
    logic [W-1:0]  r_acc, n_acc;
    logic          r_neg, n_neg;
    logic          r_dig, n_dig;
    logic [2:0]    r_frac, n_frac;
    logic [W-1:0]  r_vals [3];
    logic [W-1:0]  n_vals [3];
    logic [1:0]    r_vcnt, n_vcnt;
    logic [3:0]    r_flags, n_flags;
    logic          r_lvalid, n_lvalid;

    // Shared arithmetic: one saturating digit step and one commit of the
    // accumulated magnitude.
    logic [3:0]    dval;
    logic [W+3:0]  mac_sum;
    logic [W-1:0]  acc_mac;
    logic          key_fl;
    logic [19:0]   scale;
    logic [W+19:0] prod;
    logic [W-1:0]  cmag;
    logic [W-1:0]  cval;

    always_comb begin
        dval    = i_char[3:0] - 4'd0;
        mac_sum = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + (W+4)'(dval);
        acc_mac = (mac_sum > (W+4)'(CAP_W)) ? CAP_W : mac_sum[W-1:0];
        key_fl  = (r_key == K_MPOS) || (r_key == K_WPOS) || (r_key == K_WCO);
        scale   = key_fl ? pow10(3'(FRAC_DIGITS) - r_frac) : 20'd1;
        prod    = (W+20)'(r_acc) * (W+20)'(scale);
        cmag    = (prod > (W+20)'(CAP_W)) ? CAP_W : prod[W-1:0];
        if (r_neg) begin
            cval = {W{1'b0}} - cmag;
        end else begin
            cval = cmag[W-1] ? CAP_W - {{(W-1){1'b0}}, 1'b1} : cmag;
        end
    end

    // Candidate name matching over the state names or the field keys.
    logic          sel_key;
    logic [11:0]   match_step;
    logic          found;
    logic [3:0]    found_idx;
    logic [2:0]    found_code;

    always_comb begin
        sel_key    = (r_phase == PH_KEY);
        match_step = 12'd0;
        found      = 1'b0;
        found_idx  = 4'd0;
        for (int i = 0; i < N_STATES; i++) begin
            if (!sel_key && r_match[i] && r_nlen < ST_LEN[i]
                && ST_TXT[i][3'(r_nlen)] == i_char) begin
                match_step[i] = 1'b1;
            end
        end
        for (int i = 0; i < N_KEYS; i++) begin
            if (sel_key && r_match[i] && r_nlen < KEY_LEN[i]
                && KEY_TXT[i][2'(r_nlen)] == i_char) begin
                match_step[i] = 1'b1;
            end
        end
        for (int i = N_STATES - 1; i >= 0; i--) begin
            if (sel_key) begin
                if (i < N_KEYS && r_match[i] && KEY_LEN[i] == r_nlen) begin
                    found     = 1'b1;
                    found_idx = 4'(i);
                end
            end else if (r_match[i] && ST_LEN[i] == r_nlen) begin
                found     = 1'b1;
                found_idx = 4'(i);
            end
        end
        found_code = found ? ST_CODE[found_idx] : 3'd0;
    end

    logic          is_dig, is_ws, is_delim;
    logic [1:0]    need;
    logic          commit_now;
    logic [1:0]    cnt_c;
    logic [W-1:0]  ev [3];
    logic [W-1:0]  ra, rb, rc;
    logic [3:0]    rk;
    logic [3:0]    rfl;
    logic          rok;

    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_nlen   = r_nlen;
        n_key    = r_key;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_dig    = r_dig;
        n_frac   = r_frac;
        n_vals   = r_vals;
        n_vcnt   = r_vcnt;
        n_flags  = r_flags;
        n_lvalid = r_lvalid;
        o_rec_valid = 1'b0;
        rk  = RK_STATE;
        ra  = '0;
        rb  = '0;
        rc  = '0;
        rfl = 4'd0;
        rok = 1'b0;

        is_dig   = (i_char >= "0") && (i_char <= "9");
        is_ws    = (i_char == " ") || (i_char == 8'h09) || (i_char == 8'h0a)
                   || (i_char == 8'h0b) || (i_char == 8'h0c) || (i_char == 8'h0d);
        is_delim = (i_char == "|") || (i_char == ">") || (i_char == 8'h00);
        need     = (r_key == K_FS) ? 2'd2 :
                   ((r_key == K_F) || (r_key == K_SUB)) ? 2'd1 : 2'd3;

        // A number in progress is committed when it ends here.
        commit_now = 1'b0;
        if ((r_phase == PH_INT && !is_dig && !(i_char == "." && key_fl))
            || (r_phase == PH_FRAC && !is_dig && r_dig)) begin
            commit_now = 1'b1;
        end
        ev    = r_vals;
        cnt_c = r_vcnt;
        if (commit_now && r_vcnt != 2'd3) begin
            ev[r_vcnt[1:0]] = cval;
            cnt_c = r_vcnt + 2'd1;
        end

        if (i_done) begin
            o_rec_valid = 1'b1;
            rk       = RK_DONE;
            rok      = r_lvalid;
            n_phase  = PH_START;
            n_match  = {3'b000, {N_STATES{1'b1}}};
            n_nlen   = 4'd0;
            n_key    = K_NONE;
            n_acc    = '0;
            n_neg    = 1'b0;
            n_dig    = 1'b0;
            n_frac   = 3'd0;
            n_vals   = '{default: '0};
            n_vcnt   = 2'd0;
            n_flags  = 4'd0;
            n_lvalid = 1'b0;
        end else if (r_phase == PH_START) begin
            if (i_char == "<") begin
                n_lvalid = 1'b1;
                n_phase  = PH_NAME;
                n_match  = {3'b000, {N_STATES{1'b1}}};
                n_nlen   = 4'd0;
            end else if (!((i_char == " ") || (i_char == 8'h09) || (i_char == 8'h0d)
                           || (i_char == 8'h0a))) begin
                n_phase = PH_DISCARD;
            end
        end else if (r_phase != PH_DISCARD && is_delim) begin
            // The field ends here.
            n_vals = ev;
            n_vcnt = cnt_c;
            if (r_phase == PH_NAME) begin
                o_rec_valid = 1'b1;
                rk = RK_STATE;
                ra = W'(found_code);
            end else if (r_phase >= PH_LEAD && r_phase <= PH_REST) begin
                if (r_key == K_SUB) begin
                    o_rec_valid = 1'b1;
                    rk = RK_STATE;
                    ra = ev[1];
                    rb = ev[0];
                end else if (r_key == K_FS && cnt_c != 2'd0) begin
                    o_rec_valid = 1'b1;
                    rk = RK_FS;
                    ra = ev[0];
                    rb = (cnt_c >= 2'd2) ? ev[1] : '0;
                end else if (r_key == K_F && cnt_c != 2'd0) begin
                    o_rec_valid = 1'b1;
                    rk = RK_F;
                    ra = ev[0];
                end else if (cnt_c == 2'd3 && (key_fl || r_key == K_OV)) begin
                    o_rec_valid = 1'b1;
                    rk = (r_key == K_OV) ? RK_OV : r_key;
                    ra = ev[0];
                    rb = ev[1];
                    rc = ev[2];
                end
            end else if (r_phase == PH_FLAGS) begin
                o_rec_valid = 1'b1;
                rk  = (r_key == K_A) ? RK_ACC : RK_PINS;
                rfl = r_flags;
            end
            if (i_char == "|") begin
                n_phase = PH_KEY;
                n_key   = K_NONE;
                n_match = {4'b0000, {N_KEYS{1'b1}}};
                n_nlen  = 4'd0;
            end else begin
                n_phase = PH_DISCARD;
            end
        end else if (r_phase != PH_DISCARD) begin
            case (r_phase)
                PH_NAME: begin
                    if (i_char == ":") begin
                        n_vals[1] = W'(found_code);
                        n_vals[0] = '0;
                        n_key     = K_SUB;
                        n_vcnt    = 2'd0;
                        n_acc     = '0;
                        n_neg     = 1'b0;
                        n_dig     = 1'b0;
                        n_frac    = 3'd0;
                        n_phase   = PH_LEAD;
                    end else begin
                        n_match = match_step;
                        n_nlen  = (r_nlen == 4'd15) ? r_nlen : r_nlen + 4'd1;
                    end
                end
                PH_KEY: begin
                    if (i_char != ":") begin
                        n_match = match_step;
                        n_nlen  = (r_nlen == 4'd15) ? r_nlen : r_nlen + 4'd1;
                    end else if (!found) begin
                        n_key   = K_NONE;
                        n_phase = PH_SKIP;
                    end else begin
                        n_key = found_idx + 4'd1;
                        if (found_idx + 4'd1 == K_A || found_idx + 4'd1 == K_PN) begin
                            n_flags = 4'd0;
                            n_phase = PH_FLAGS;
                        end else begin
                            n_vals  = '{default: '0};
                            n_vcnt  = 2'd0;
                            n_acc   = '0;
                            n_neg   = 1'b0;
                            n_dig   = 1'b0;
                            n_frac  = 3'd0;
                            n_phase = PH_LEAD;
                        end
                    end
                end
                PH_FLAGS: begin
                    if (r_key == K_A) begin
                        if (i_char == "S") n_flags[0] = 1'b1;
                        if (i_char == "C") n_flags[1] = 1'b1;
                        if (i_char == "F") n_flags[2] = 1'b1;
                        if (i_char == "M") n_flags[3] = 1'b1;
                    end else begin
                        if (i_char == "P") n_flags[0] = 1'b1;
                        if (i_char == "X") n_flags[1] = 1'b1;
                        if (i_char == "Y") n_flags[2] = 1'b1;
                        if (i_char == "Z") n_flags[3] = 1'b1;
                    end
                end
                PH_LEAD, PH_SIGN: begin
                    if (r_phase == PH_LEAD && is_ws) begin
                        n_phase = PH_LEAD;
                    end else if (r_phase == PH_LEAD && (i_char == "+" || i_char == "-")) begin
                        n_neg   = (i_char == "-");
                        n_phase = PH_SIGN;
                    end else if (is_dig) begin
                        n_acc   = acc_mac;
                        n_phase = PH_INT;
                    end else if (i_char == "." && key_fl) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_REST;
                    end
                end
                PH_INT, PH_FRAC: begin
                    if (r_phase == PH_INT && is_dig) begin
                        n_acc = acc_mac;
                    end else if (r_phase == PH_INT && i_char == "." && key_fl) begin
                        n_dig   = 1'b1;
                        n_phase = PH_FRAC;
                    end else if (r_phase == PH_FRAC && is_dig) begin
                        n_dig = 1'b1;
                        if (r_frac < 3'(FRAC_DIGITS)) begin
                            n_acc  = acc_mac;
                            n_frac = r_frac + 3'd1;
                        end
                    end else if (commit_now) begin
                        n_vals = ev;
                        n_vcnt = cnt_c;
                        if (i_char == "," && cnt_c < need) begin
                            n_acc   = '0;
                            n_neg   = 1'b0;
                            n_dig   = 1'b0;
                            n_frac  = 3'd0;
                            n_phase = PH_LEAD;
                        end else begin
                            n_phase = PH_REST;
                        end
                    end else begin
                        n_phase = PH_REST;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Values are narrowed or sign-extended to the 32-bit result fields.
    logic [63:0] wa, wb, wc;
    always_comb begin
        wa = 64'(signed'(ra));
        wb = 64'(signed'(rb));
        wc = 64'(signed'(rc));
        o_rec.kind  = rk;
        o_rec.val_a = wa[31:0];
        o_rec.val_b = wb[31:0];
        o_rec.val_c = wc[31:0];
        o_rec.flags = rfl;
        o_rec.ok    = rok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_match  <= {3'b000, {N_STATES{1'b1}}};
            r_nlen   <= 4'd0;
            r_key    <= K_NONE;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_dig    <= 1'b0;
            r_frac   <= 3'd0;
            r_vals   <= '{default: '0};
            r_vcnt   <= 2'd0;
            r_flags  <= 4'd0;
            r_lvalid <= 1'b0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_nlen   <= n_nlen;
            r_key    <= n_key;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_dig    <= n_dig;
            r_frac   <= n_frac;
            r_vals   <= n_vals;
            r_vcnt   <= n_vcnt;
            r_flags  <= n_flags;
            r_lvalid <= n_lvalid;
        end
    end

endmodule

>>> sv/cnc_status_report_parser.sv
// Top level of the status report parser: input register, line-end
// sequencing and result register. Depends on csrp_pkg and csrp_parser.
`timescale 1ns / 1ps
// A status line enters one byte per transfer, with i_line_end set on its
// last byte. Each byte is registered and parsed once the result register
// is free or being emptied, and a new byte is taken in every cycle while
// results are being taken and no line-end pass runs. A parser pass gives
// at most one record (state, MPos, WPos, WCO, FS, F, Ov, A or Pn) when it
// closes a field. The byte that ends a line is followed by a closing pass
// that finishes a field left open and a pass that sends the done record
// carrying line_ok and clears the parser for the next line. Results wait
// in an output register, and a byte is not taken while a record that is
// still untaken would be overwritten. Coordinates are signed values scaled
// by 10^FRAC_DIGITS, truncated and saturated to VALUE_WIDTH bits.
module cnc_status_report_parser #(
    parameter int FRAC_DIGITS = csrp_pkg::FRAC_DIGITS_DEF,
    parameter int VALUE_WIDTH = csrp_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_line_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_record_kind,
    output logic signed [31:0] o_value_a,
    output logic signed [31:0] o_value_b,
    output logic signed [31:0] o_value_c,
    output logic [3:0]  o_flag_bits,
    output logic        o_line_ok,
    output logic        o_last_record
);
    import csrp_pkg::*;

    // Passes over the held byte.
    localparam logic [1:0] PASS_BYTE = 2'd0;
    localparam logic [1:0] PASS_ZERO = 2'd1;
    localparam logic [1:0] PASS_DONE = 2'd2;

    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_last;
    logic [1:0]  r_pass;
    logic        r_out_valid;
    t_record     r_rec;
    logic        r_rec_last;

    logic        step_go;
    logic        step_end;
    logic        rec_valid;
    t_record     rec;

    // The parser steps when a byte is held and the result register is free
    // or is being emptied in this cycle.
    assign step_go  = r_in_valid && (!r_out_valid || i_ready);
    assign step_end = !r_last || (r_pass == PASS_DONE);
    assign o_ready  = !r_in_valid || (step_go && step_end);

    csrp_parser #(
        .FRAC_DIGITS(FRAC_DIGITS),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (step_go),
        .i_char      ((r_pass == PASS_ZERO) ? 8'h00 : r_char),
        .i_done      (r_pass == PASS_DONE),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pass     <= PASS_BYTE;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
                r_pass     <= PASS_BYTE;
            end else if (step_go) begin
                r_pass <= r_pass + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char_in;
            r_last <= i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= rec_valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // A record is the last of its byte unless the line-end passes follow.
    always_ff @(posedge i_clk) begin
        if (step_go && rec_valid) begin
            r_rec      <= rec;
            r_rec_last <= step_end;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_record_kind = r_rec.kind;
    assign o_value_a     = r_rec.val_a;
    assign o_value_b     = r_rec.val_b;
    assign o_value_c     = r_rec.val_c;
    assign o_flag_bits   = r_rec.flags;
    assign o_line_ok     = r_rec.ok;
    assign o_last_record = r_rec_last;

    // The done pass always leaves a done record that closes its byte.
    a_done_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go && r_pass == PASS_DONE |=> o_valid && o_record_kind == RK_DONE
        && o_last_record)
        else $error("done pass did not produce a closing done record");

    // Extra passes only happen on a held line-end byte.
    a_pass_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass != PASS_BYTE |-> r_in_valid && r_last)
        else $error("line-end pass without a held line-end byte");

    // Only the done record may carry line validity.
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_ok |-> o_record_kind == RK_DONE)
        else $error("line_ok set on a record other than done");

endmodule

>>> tb/sv/csrp_checker.sv
// Checker for the status report parser: tracks byte and record transfers,
// predicts the records of each byte and compares them. Depends on csrp_pkg.
`timescale 1ns / 1ps
module csrp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_line_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_record_kind,
    input  logic [31:0] i_value_a,
    input  logic [31:0] i_value_b,
    input  logic [31:0] i_value_c,
    input  logic [3:0]  i_flag_bits,
    input  logic        i_line_ok,
    input  logic        i_last_record,
    output int          o_fail_count,
    output int          o_pending
);
    import csrp_pkg::*;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [3:0]  flags;
        logic        ok;
        logic        last;
    } t_status_rec;

    localparam longint unsigned MAG_LIMIT = 64'd1 << (VALUE_WIDTH_DEF - 1);
    localparam int FRAC_KEEP = FRAC_DIGITS_DEF;

    string state_names [9] = '{"Idle", "Run", "Hold", "Jog", "Home", "Alarm", "Door",
                               "Check", "Sleep"};
    int    state_codes [9] = '{0, 1, 2, 3, 4, 5, 2, 0, 0};
    string key_names [8] = '{"MPos", "WPos", "WCO", "FS", "F", "Ov", "A", "Pn"};

    // Shadow copy of the parser state.
    logic [3:0]      phase;
    logic [11:0]     cand;
    int              match_len;
    logic [3:0]      key;
    longint unsigned num_mag;
    logic [5:0]      num_info;
    longint unsigned vals [3];
    int              val_cnt;
    logic [3:0]      flag_acc;
    logic            line_valid;

    t_status_rec byte_records[$];
    t_status_rec expected_records[$];
    int fails = 0;

    assign o_fail_count = fails;

    function automatic longint unsigned mul_add_sat(longint unsigned m, int d);
        if (m > (MAG_LIMIT - d) / 10) return MAG_LIMIT;
        return m * 10 + d;
    endfunction

    function automatic bit is_ws(logic [7:0] ch);
        return ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13);
    endfunction

    function automatic bit coord_key();
        return key == K_MPOS || key == K_WPOS || key == K_WCO;
    endfunction

    function automatic int values_needed();
        if (key == K_FS) return 2;
        if (key == K_F || key == K_SUB) return 1;
        return 3;
    endfunction

    function automatic string cand_name(bit states, int i);
        return states ? state_names[i] : key_names[i];
    endfunction

    task automatic restart_match(int n);
        cand = 12'((1 << n) - 1);
        match_len = 0;
    endtask

    task automatic match_char(bit states, logic [7:0] ch);
        string nm;
        for (int i = 0; i < (states ? 9 : 8); i++) begin
            nm = cand_name(states, i);
            if (cand[i] && (match_len >= nm.len() || nm[match_len] != ch)) cand[i] = 1'b0;
        end
        if (match_len < 15) match_len++;
    endtask

    function automatic int matched_index(bit states);
        for (int i = 0; i < (states ? 9 : 8); i++)
            if (cand[i] && cand_name(states, i).len() == match_len) return i;
        return -1;
    endfunction

    task automatic add_record(logic [3:0] kind, longint unsigned a, longint unsigned b,
                              longint unsigned c, logic [3:0] flags, logic ok);
        t_status_rec r;
        r.kind = kind;
        r.a = a[31:0];
        r.b = b[31:0];
        r.c = c[31:0];
        r.flags = flags;
        r.ok = ok;
        r.last = 1'b0;
        byte_records.push_back(r);
    endtask

    task automatic clear_number();
        num_mag = 0;
        num_info = '0;
    endtask

    task automatic store_number();
        longint unsigned m;
        longint unsigned v;
        m = num_mag;
        if (coord_key())
            for (int k = int'(num_info[5:2]); k < FRAC_KEEP; k++) m = mul_add_sat(m, 0);
        if (num_info[0]) v = 64'd0 - m;
        else v = (m >= MAG_LIMIT) ? MAG_LIMIT - 1 : m;
        if (val_cnt < 3) begin
            vals[val_cnt] = v;
            val_cnt++;
        end
    endtask

    task automatic next_value(logic [7:0] ch);
        if (ch == "," && val_cnt < values_needed()) begin
            clear_number();
            phase = PH_LEAD;
        end else begin
            phase = PH_REST;
        end
    endtask

    task automatic number_char(logic [7:0] ch);
        bit fl;
        bit dig;
        int d;
        logic [3:0] p;
        logic [3:0] f;
        fl = coord_key();
        dig = ch >= "0" && ch <= "9";
        d = int'(ch) - 48;
        p = phase;
        if (p == PH_LEAD) begin
            if (is_ws(ch)) return;
            if (ch == "+" || ch == "-") begin
                if (ch == "-") num_info[0] = 1'b1;
                phase = PH_SIGN;
                return;
            end
            // Any other byte is handled as if the sign had been passed.
            p = PH_SIGN;
        end
        case (p)
            PH_SIGN: begin
                if (dig) begin
                    num_mag = mul_add_sat(num_mag, d);
                    phase = PH_INT;
                end else if (ch == "." && fl) phase = PH_FRAC;
                else phase = PH_REST;
            end
            PH_INT: begin
                if (dig) num_mag = mul_add_sat(num_mag, d);
                else if (ch == "." && fl) begin
                    num_info[1] = 1'b1;
                    phase = PH_FRAC;
                end else begin
                    store_number();
                    next_value(ch);
                end
            end
            PH_FRAC: begin
                if (dig) begin
                    f = num_info[5:2];
                    num_info[1] = 1'b1;
                    if (f < FRAC_KEEP) begin
                        num_mag = mul_add_sat(num_mag, d);
                        num_info[5:2] = f + 4'd1;
                    end
                end else if (num_info[1]) begin
                    store_number();
                    next_value(ch);
                end else begin
                    phase = PH_REST;
                end
            end
            default: ;
        endcase
    endtask

    task automatic close_field(logic [7:0] ch);
        logic [3:0] ph;
        int i;
        ph = phase;
        if (ph >= PH_LEAD && ph <= PH_FRAC) begin
            number_char(8'd0);
            ph = phase;
        end
        if (ph == PH_NAME) begin
            i = matched_index(1'b1);
            add_record(RK_STATE, i < 0 ? 0 : state_codes[i], 0, 0, 4'd0, 1'b0);
        end else if (ph == PH_REST && key == K_SUB) begin
            add_record(RK_STATE, vals[1], vals[0], 0, 4'd0, 1'b0);
        end else if (ph == PH_REST) begin
            if (key == K_FS && val_cnt >= 1)
                add_record(RK_FS, vals[0], val_cnt >= 2 ? vals[1] : 0, 0, 4'd0, 1'b0);
            else if (key == K_F && val_cnt >= 1)
                add_record(RK_F, vals[0], 0, 0, 4'd0, 1'b0);
            else if (val_cnt == 3 && (coord_key() || key == K_OV))
                add_record(key == K_OV ? RK_OV : key, vals[0], vals[1], vals[2], 4'd0, 1'b0);
        end else if (ph == PH_FLAGS) begin
            add_record(key == K_A ? RK_ACC : RK_PINS, 0, 0, 0, flag_acc, 1'b0);
        end
        if (ch == "|") begin
            phase = PH_KEY;
            key = K_NONE;
            restart_match(8);
        end else begin
            phase = PH_DISCARD;
        end
    endtask

    task automatic field_char(logic [7:0] ch);
        int i;
        case (phase)
            PH_NAME: begin
                if (ch == ":") begin
                    i = matched_index(1'b1);
                    vals[1] = i < 0 ? 0 : state_codes[i];
                    vals[0] = 0;
                    key = K_SUB;
                    val_cnt = 0;
                    clear_number();
                    phase = PH_LEAD;
                end else begin
                    match_char(1'b1, ch);
                end
            end
            PH_KEY: begin
                if (ch != ":") match_char(1'b0, ch);
                else begin
                    i = matched_index(1'b0);
                    key = i < 0 ? K_NONE : 4'(i + 1);
                    if (i < 0) phase = PH_SKIP;
                    else if (key == K_A || key == K_PN) begin
                        flag_acc = '0;
                        phase = PH_FLAGS;
                    end else begin
                        vals = '{0, 0, 0};
                        val_cnt = 0;
                        clear_number();
                        phase = PH_LEAD;
                    end
                end
            end
            PH_FLAGS: begin
                if (key == K_A) begin
                    if (ch == "S") flag_acc[0] = 1'b1;
                    else if (ch == "C") flag_acc[1] = 1'b1;
                    else if (ch == "F") flag_acc[2] = 1'b1;
                    else if (ch == "M") flag_acc[3] = 1'b1;
                end else begin
                    if (ch == "P") flag_acc[0] = 1'b1;
                    else if (ch == "X") flag_acc[1] = 1'b1;
                    else if (ch == "Y") flag_acc[2] = 1'b1;
                    else if (ch == "Z") flag_acc[3] = 1'b1;
                end
            end
            PH_LEAD, PH_SIGN, PH_INT, PH_FRAC: number_char(ch);
            default: ;
        endcase
    endtask

    task automatic clear_parser();
        phase = PH_START;
        restart_match(9);
        key = K_NONE;
        clear_number();
        vals = '{0, 0, 0};
        val_cnt = 0;
        flag_acc = '0;
        line_valid = 1'b0;
    endtask

    // Works out the records one byte causes and queues them.
    task automatic predict_byte(logic [7:0] ch, logic last);
        logic ok;
        byte_records.delete();
        if (phase == PH_START) begin
            if (ch == "<") begin
                line_valid = 1'b1;
                phase = PH_NAME;
                restart_match(9);
            end else if (!(ch == 8'd32 || ch == 8'd9 || ch == 8'd13 || ch == 8'd10)) begin
                phase = PH_DISCARD;
            end
        end else if (phase != PH_DISCARD) begin
            if (ch == "|" || ch == ">" || ch == 8'd0) close_field(ch);
            else field_char(ch);
        end
        if (last) begin
            ok = line_valid;
            if (phase != PH_START && phase != PH_DISCARD) close_field(8'd0);
            add_record(RK_DONE, 0, 0, 0, 4'd0, ok);
            clear_parser();
        end
        if (byte_records.size() > 0) byte_records[byte_records.size() - 1].last = 1'b1;
        foreach (byte_records[i]) expected_records.push_back(byte_records[i]);
    endtask

    initial clear_parser();

    always @(posedge i_clk) begin
        t_status_rec got;
        t_status_rec exp_rec;
        if (i_rst_n) begin
            // Records leave before the byte of this edge adds its own.
            if (i_out_valid && i_out_ready) begin
                got = '{i_record_kind, i_value_a, i_value_b, i_value_c, i_flag_bits,
                        i_line_ok, i_last_record};
                if (expected_records.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected record, expected none, actual kind=%0d a=%0d b=%0d c=%0d",
                             $time, got.kind, $signed(got.a), $signed(got.b), $signed(got.c));
                end else begin
                    exp_rec = expected_records.pop_front();
                    if (got != exp_rec) begin
                        fails++;
                        $display("%0t: record mismatch expected %p actual %p",
                                 $time, exp_rec, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_byte(i_char_in, i_line_end);
        end
        o_pending <= expected_records.size();
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the status report parser testbench: clock, reset, byte stimulus,
// record sink and verdict. Depends on csrp_pkg, csrp_checker and the parser.
`timescale 1ns / 1ps
module testbench;
    import csrp_pkg::*;

    localparam int BYTE_TARGET = 700;
    localparam int CALM_FROM = 600;
    localparam int HOLD_AT = 250;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_in = 8'd0;
    logic        i_line_end = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_record_kind;
    logic signed [31:0] o_value_a;
    logic signed [31:0] o_value_b;
    logic signed [31:0] o_value_c;
    logic [3:0]  o_flag_bits;
    logic        o_line_ok;
    logic        o_last_record;

    int fail_count;
    int pending;
    int bytes_sent = 0;
    int cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    logic [7:0] line_bytes[$];

    cnc_status_report_parser uut (.*);

    csrp_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_char_in(i_char_in), .i_line_end(i_line_end),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_record_kind(o_record_kind), .i_value_a(o_value_a), .i_value_b(o_value_b),
        .i_value_c(o_value_c), .i_flag_bits(o_flag_bits), .i_line_ok(o_line_ok),
        .i_last_record(o_last_record),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run is cut off once the cycle count passes CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Record sink: random stall and ready bursts, one long hold-off that lets
    // the parser fill up, and no stalls at all near the end of the run.
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endtask

    // Sends one byte; the transfer happens at the first rising edge at which
    // o_ready is high, which is checked at the falling edge ahead of that edge.
    task automatic send_byte(logic [7:0] ch, logic last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_in <= ch;
        i_line_end <= last;
        forever begin
            @(negedge i_clk);
            if (o_ready) break;
        end
        @(posedge i_clk);
        bytes_sent++;
        if (bytes_sent == HOLD_AT) hold_req = 1'b1;
        if (bytes_sent >= CALM_FROM) calm = 1'b1;
    endtask

    // Sends the collected line with the line end flag on its last byte.
    task automatic send_line();
        foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
        line_bytes.delete();
    endtask

    function automatic string rand_number(bit coord);
        string s;
        int n;
        s = "";
        if ($urandom_range(0, 9) == 0) s = " ";
        case ($urandom_range(0, 3))
            0: s = {s, "-"};
            1: s = {s, "+"};
            default: ;
        endcase
        // Long digit runs push the value into saturation.
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 4);
        if (n == 0 && !coord) n = 1;
        for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        if (coord && (n == 0 || $urandom_range(0, 1))) begin
            s = {s, "."};
            repeat ($urandom_range(0, 5)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        end
        if ($urandom_range(0, 19) == 0) s = {s, "x"};
        return s;
    endfunction

    function automatic string rand_list(int count, bit coord);
        string s;
        s = rand_number(coord);
        for (int i = 1; i < count; i++) s = {s, ",", rand_number(coord)};
        return s;
    endfunction

    function automatic string rand_letters(string pool);
        string s;
        s = "";
        repeat ($urandom_range(0, 5)) s = {s, pool.substr($urandom_range(0, pool.len() - 1),
                                                             $urandom_range(0, pool.len() - 1) + 0)};
        return s;
    endfunction

    // Builds one random line, mostly a well-formed status report.
    task automatic build_line();
        string names [11] = '{"Idle", "Run", "Hold", "Jog", "Home", "Alarm", "Door", "Check",
                              "Sleep", "Hol", "Runx"};
        string keys [10] = '{"MPos", "WPos", "WCO", "FS", "F", "Ov", "A", "Pn", "Bf", "MPo"};
        int k;
        if ($urandom_range(0, 9) == 0) begin
            // Noise: arbitrary bytes, zero bytes included.
            repeat ($urandom_range(1, 10)) line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) add_text(($urandom_range(0, 1)) ? " " : "\t");
        if ($urandom_range(0, 19) == 0) add_text("\r\n");
        if ($urandom_range(0, 19) == 0) add_text("#");
        add_text("<");
        add_text(names[$urandom_range(0, 10)]);
        if ($urandom_range(0, 2) == 0) add_text({":", rand_number(1'b0)});
        repeat ($urandom_range(0, 6)) begin
            add_text("|");
            k = $urandom_range(0, 9);
            add_text(keys[k]);
            if ($urandom_range(0, 15) != 0) begin
                add_text(":");
                case (k)
                    0, 1, 2: add_text(rand_list($urandom_range(0, 7) == 0 ?
                                                $urandom_range(1, 4) : 3, 1'b1));
                    3:       add_text(rand_list($urandom_range(1, 3), 1'b0));
                    4:       add_text(rand_list($urandom_range(1, 2), 1'b0));
                    5:       add_text(rand_list($urandom_range(2, 4), 1'b0));
                    6:       add_text(rand_letters("SCFMxP"));
                    7:       add_text(rand_letters("PXYZAs"));
                    default: add_text(rand_number(1'b1));
                endcase
            end
        end
        case ($urandom_range(0, 9))
            0, 1: ;
            2:    line_bytes.push_back(8'd0);
            3:    add_text("|");
            default: begin
                add_text(">");
                if ($urandom_range(0, 3) == 0) add_text("|F:5\r");
            end
        endcase
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines: substate, all flag letters, an unterminated line
        // with saturating and fraction-only coordinates, and a rejected line.
        add_text("<Door:3|A:SCFM|Pn:PXYZ>");
        send_line();
        add_text(" <Home|MPos:-99999999,.5,1.2345");
        send_line();
        add_text("x<");
        send_line();

        while (bytes_sent < BYTE_TARGET) begin
            build_line();
            send_line();
        end
        i_valid <= 1'b0;
        i_line_end <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
